// File: hdl/srr_pkg.sv
`timescale 1ns / 1ps

package srr_pkg;

  localparam int DATA_W = 32;
  localparam int ERR_W  = 31;

  localparam logic [ERR_W-1:0] ERR_SAT = {ERR_W{1'b1}};
  localparam logic [DATA_W-1:0] DATA_POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ERR,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_SWEEP,
    ST_EMIT
  } state_t;

endpackage

// File: hdl/srr_div.sv
`timescale 1ns / 1ps

// Signed dividend over an unsigned nonzero divisor, quotient truncated toward zero.
// One quotient bit per cycle, restoring.
module srr_div #(
  parameter int W  = 37,
  parameter int DW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] dividend,
  input  logic [DW-1:0]       divisor,
  output logic                done,
  output logic signed [W-1:0] quotient
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic          neg;
  logic [DW-1:0] rem;
  logic [W-1:0]  quo;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   trial_diff;
  logic          trial_ge;
  logic [DW-1:0] rem_next;

  assign trial      = {rem, quo[W-1]};
  assign trial_ge   = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};
  assign rem_next   = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
  assign quotient   = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[W-1];
      quo <= dividend[W-1] ? W'(-dividend) : W'(dividend);
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[W-2:0], trial_ge};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// File: hdl/stochastic_row_regularizer.sv
`timescale 1ns / 1ps
// Entries are written to the row memory as they are accepted; the row error is then registered in ST_ERR.
// Each projection pass runs the divider and then sweeps the row; a row of n entries needs at most n passes.
// Results leave one at a time from the row memory's registered read port, each read loaded before the next issues.
// Throughput is one row at a time; the next row is taken once its last result is registered.
// Reset clears the control state and the running maximum; the row memory is not cleared.

module stochastic_row_regularizer #(
  parameter int ROW_MAX   = 16,
  parameter int FRAC_BITS = 28
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] entry_value,
  input  logic               row_end,
  input  logic               new_matrix,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_value,
  output logic [30:0]        row_error,
  output logic [30:0]        max_error,
  output logic               zero_row,
  output logic               last_out
);

  localparam int IDX_W = $clog2(ROW_MAX);
  localparam int CNT_W = $clog2(ROW_MAX + 1);
  localparam int SUM_W = 33 + IDX_W;
  localparam int ABS_W = 32 + IDX_W;
  localparam logic [ABS_W-1:0] ONE_ABS = ABS_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W:0] POS_MAX =
    (SUM_W+1)'(srr_pkg::DATA_POS_MAX);

  srr_pkg::state_t state, state_next;

  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        row_len;
  logic [ABS_W-1:0]        abs_sum;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        nnz;
  logic                    any_nz;
  logic                    zero_r;
  logic [30:0]             err_r;
  logic [30:0]             max_r;
  logic signed [SUM_W-1:0] lambda;
  logic                    clamped;
  logic [CNT_W-1:0]        sw_idx;
  logic                    sw_pend;
  logic [IDX_W-1:0]        sw_addr;
  logic [CNT_W-1:0]        e_idx;
  logic                    rd_pend;
  logic                    e_last;

  logic signed [31:0] mem [ROW_MAX];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic signed [31:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic signed [31:0] mem_rdata;

  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] div_q;

  logic               in_acc;
  logic               row_done;
  logic [31:0]        entry_abs;
  logic               abs_ge;
  logic [ABS_W-1:0]   diff_pos;
  logic [ABS_W-1:0]   diff_neg;
  logic [ABS_W-1:0]   diff_mag;
  logic [30:0]        err_new;
  logic signed [SUM_W:0] sw_d;
  logic               sw_neg;
  logic               sw_big;
  logic               sw_nz;
  logic signed [31:0] sw_y;
  logic               sw_issue;
  logic               sweep_done;
  logic               e_issue;

  srr_div #(
    .W  (SUM_W),
    .DW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum - ONE_SUM),
    .divisor  (nnz),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall  = (state != srr_pkg::ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign row_done  = in_acc && (row_end || cnt == CNT_W'(ROW_MAX - 1));
  assign entry_abs = entry_value[31] ? 32'(-entry_value) : 32'(entry_value);

  assign abs_ge   = abs_sum >= ONE_ABS;
  assign diff_pos = abs_sum - ONE_ABS;
  assign diff_neg = ONE_ABS - abs_sum;
  assign diff_mag = abs_ge ? diff_pos : diff_neg;
  assign err_new  = (diff_mag > ABS_W'(srr_pkg::ERR_SAT)) ? srr_pkg::ERR_SAT
                                                          : diff_mag[30:0];

  assign sw_nz  = (mem_rdata != 32'sd0);
  assign sw_d   = (SUM_W+1)'(mem_rdata) - (SUM_W+1)'(lambda);
  assign sw_neg = sw_d[SUM_W];
  assign sw_big = !sw_neg && (sw_d > POS_MAX);

  always_comb begin
    if (!sw_nz || sw_neg) begin
      sw_y = 32'sd0;
    end else if (sw_big) begin
      sw_y = $signed(srr_pkg::DATA_POS_MAX);
    end else begin
      sw_y = sw_d[31:0];
    end
  end

  assign sw_issue   = (state == srr_pkg::ST_SWEEP) && (sw_idx < row_len);
  assign sweep_done = (state == srr_pkg::ST_SWEEP) && (sw_idx == row_len) && !sw_pend;
  assign e_issue    = (state == srr_pkg::ST_EMIT) && !rd_pend && (e_idx < row_len) &&
                      (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      srr_pkg::ST_LOAD: begin
        if (row_done) state_next = srr_pkg::ST_ERR;
      end
      srr_pkg::ST_ERR: begin
        state_next = zero_r ? srr_pkg::ST_EMIT : srr_pkg::ST_DIV_START;
      end
      srr_pkg::ST_DIV_START: begin
        state_next = (nnz == '0) ? srr_pkg::ST_EMIT : srr_pkg::ST_DIV_WAIT;
      end
      srr_pkg::ST_DIV_WAIT: begin
        if (div_done) state_next = srr_pkg::ST_SWEEP;
      end
      srr_pkg::ST_SWEEP: begin
        if (sweep_done) state_next = clamped ? srr_pkg::ST_DIV_START : srr_pkg::ST_EMIT;
      end
      srr_pkg::ST_EMIT: begin
        if (rd_pend && e_last) state_next = srr_pkg::ST_LOAD;
      end
      default: state_next = srr_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt[IDX_W-1:0];
    mem_wdata = entry_value;
    mem_raddr = sw_idx[IDX_W-1:0];
    div_start = 1'b0;
    case (state)
      srr_pkg::ST_LOAD: begin
        mem_we = in_acc;
      end
      srr_pkg::ST_DIV_START: begin
        div_start = (nnz != '0);
      end
      srr_pkg::ST_SWEEP: begin
        mem_we    = sw_pend;
        mem_waddr = sw_addr;
        mem_wdata = sw_y;
      end
      srr_pkg::ST_EMIT: begin
        mem_raddr = e_idx[IDX_W-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srr_pkg::ST_LOAD;
      cnt       <= '0;
      abs_sum   <= '0;
      sum       <= '0;
      nnz       <= '0;
      any_nz    <= 1'b0;
      max_r     <= '0;
      sw_idx    <= '0;
      sw_pend   <= 1'b0;
      e_idx     <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (in_acc) begin
        if (new_matrix) max_r <= '0;
        abs_sum <= abs_sum + ABS_W'(entry_abs);
        sum     <= sum + SUM_W'(entry_value);
        if (entry_value != 32'sd0) begin
          nnz    <= nnz + 1'b1;
          any_nz <= 1'b1;
        end
        if (row_done) begin
          cnt     <= '0;
          row_len <= cnt + 1'b1;
          zero_r  <= !(any_nz || entry_value != 32'sd0);
        end else begin
          cnt <= cnt + 1'b1;
        end
      end

      if (state == srr_pkg::ST_ERR) begin
        err_r   <= err_new;
        abs_sum <= '0;
        if (err_new > max_r) max_r <= err_new;
      end

      if (state == srr_pkg::ST_DIV_WAIT && div_done) begin
        lambda  <= div_q;
        sum     <= '0;
        nnz     <= '0;
        clamped <= 1'b0;
        sw_idx  <= '0;
        sw_pend <= 1'b0;
      end

      if (state == srr_pkg::ST_SWEEP) begin
        sw_pend <= sw_issue;
        if (sw_issue) begin
          sw_addr <= sw_idx[IDX_W-1:0];
          sw_idx  <= sw_idx + 1'b1;
        end
        if (sw_pend) begin
          sum <= sum + SUM_W'(sw_y);
          if (sw_y != 32'sd0) nnz <= nnz + 1'b1;
          if (sw_nz && sw_neg) clamped <= 1'b1;
        end
      end

      if (e_issue) begin
        e_idx   <= e_idx + 1'b1;
        rd_pend <= 1'b1;
        e_last  <= (e_idx + 1'b1 == row_len);
      end

      if (rd_pend) begin
        rd_pend   <= 1'b0;
        out_valid <= 1'b1;
        if (e_last) begin
          e_idx  <= '0;
          sum    <= '0;
          nnz    <= '0;
          any_nz <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_value <= mem_rdata;
      row_error <= err_r;
      max_error <= max_r;
      zero_row  <= zero_r;
      last_out  <= e_last;
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == srr_pkg::ST_DIV_WAIT)
    else $error("Divider finished outside of its wait state.");

  a_read_in_emit: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == srr_pkg::ST_EMIT)
    else $error("Result read pending outside of the emit state.");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> cnt < CNT_W'(ROW_MAX))
    else $error("Entry count reached the row capacity.");

  a_sweep_addr: assert property (@(posedge clk) disable iff (rst)
    (state == srr_pkg::ST_SWEEP && sw_pend) |-> CNT_W'(sw_addr) < row_len)
    else $error("Sweep wrote beyond the loaded row.");

  a_row_closes: assert property (@(posedge clk) disable iff (rst)
    (state == srr_pkg::ST_EMIT && rd_pend && e_last) |=>
      (state == srr_pkg::ST_LOAD && e_idx == '0 && out_valid && last_out))
    else $error("Row did not close after its last transfer was loaded.");

endmodule

// File: tb/tb_stochastic_row_regularizer.sv
`timescale 1ns / 1ps

module tb_stochastic_row_regularizer;

  localparam int ROW_MAX = 16;
  localparam int FRAC_BITS = 28;
  localparam int ONE_FIX = 1 << FRAC_BITS;
  localparam longint ERR_LIMIT = 64'h7FFF_FFFF;
  localparam int ITEM_TARGET = 450;
  localparam int HOLD_CYCLES = 2000;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] value;
    logic        last;
    logic        clear;
  } row_entry_t;

  typedef struct {
    logic [31:0] value;
    logic [30:0] err;
    logic [30:0] peak;
    logic        zero;
    logic        last;
  } row_result_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] entry_value = '0;
  logic               row_end = 1'b0;
  logic               new_matrix = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_value;
  logic [30:0]        row_error;
  logic [30:0]        max_error;
  logic               zero_row;
  logic               last_out;

  row_entry_t  entries_to_send[$];
  row_result_t awaited_results[$];
  row_entry_t  next_entry;
  row_result_t want;

  logic signed [31:0] row_buf[ROW_MAX];
  int unsigned        row_len = 0;
  longint             abs_total = 0;
  logic [30:0]        peak_err = '0;

  bit  in_took = 1'b0;
  bit  hold_off = 1'b0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  error_count = 0;
  int  entries_taken = 0;
  int  results_seen = 0;
  int  rows_closed = 0;
  int  zero_rows = 0;
  int  full_rows = 0;
  int  most_passes = 0;
  longint cycle_count = 0;

  stochastic_row_regularizer #(
    .ROW_MAX(ROW_MAX),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .entry_value(entry_value),
    .row_end(row_end),
    .new_matrix(new_matrix),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_value(out_value),
    .row_error(row_error),
    .max_error(max_error),
    .zero_row(zero_row),
    .last_out(last_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("MISMATCH at result %0d: %s got %h expected %h", results_seen, what, got,
             exp_val);
    error_count++;
  endtask

  // Simplex projection of the buffered row: repeated uniform shifts with clamping.
  task automatic simplex_project();
    longint total;
    longint shift;
    longint t;
    longint nz;
    bit     clipped;
    int     p;
    int     j;
    for (p = 0; p <= ROW_MAX; p++) begin
      total = 0;
      nz = 0;
      clipped = 1'b0;
      for (j = 0; j < row_len; j++) begin
        total += row_buf[j];
        if (row_buf[j] != 0) nz++;
      end
      if (nz == 0) return;
      if (p + 1 > most_passes) most_passes = p + 1;
      shift = (total - longint'(ONE_FIX)) / nz;
      for (j = 0; j < row_len; j++) begin
        if (row_buf[j] != 0) begin
          t = longint'(row_buf[j]) - shift;
          if (t > longint'(2147483647)) row_buf[j] = srr_pkg::DATA_POS_MAX;
          else if (t < -longint'(2147483647) - 1) row_buf[j] = ~srr_pkg::DATA_POS_MAX;
          else row_buf[j] = t[31:0];
        end
      end
      for (j = 0; j < row_len; j++) begin
        if (row_buf[j] < 0) begin
          row_buf[j] = '0;
          clipped = 1'b1;
        end
      end
      if (!clipped) return;
    end
  endtask

  task automatic fold_entry(input logic signed [31:0] v, input logic last,
                            input logic clear);
    longint      diff;
    logic [30:0] err;
    bit          all_zero;
    row_result_t r;
    int          j;
    if (clear) peak_err = '0;
    row_buf[row_len] = v;
    row_len++;
    abs_total += (v < 0) ? -longint'(v) : longint'(v);
    if (!last && row_len < ROW_MAX) return;
    if (!last) full_rows++;
    diff = abs_total - longint'(ONE_FIX);
    if (diff < 0) diff = -diff;
    err = (diff > ERR_LIMIT) ? srr_pkg::ERR_SAT : diff[30:0];
    if (err > peak_err) peak_err = err;
    all_zero = 1'b1;
    for (j = 0; j < row_len; j++)
      if (row_buf[j] != 0) all_zero = 1'b0;
    if (all_zero) zero_rows++;
    else simplex_project();
    for (j = 0; j < row_len; j++) begin
      r.value = row_buf[j];
      r.err = err;
      r.peak = peak_err;
      r.zero = all_zero;
      r.last = (j + 1 == row_len);
      awaited_results.push_back(r);
    end
    rows_closed++;
    row_len = 0;
    abs_total = 0;
  endtask

  function automatic logic [31:0] pick_entry();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 20) return '0;
    if (k < 55) return $urandom_range(0, ONE_FIX);
    if (k < 70) return -$urandom_range(1, ONE_FIX / 2);
    if (k < 85) return $urandom();
    case ($urandom_range(0, 4))
      0: return srr_pkg::DATA_POS_MAX;
      1: return ~srr_pkg::DATA_POS_MAX;
      2: return ONE_FIX;
      3: return 32'd1;
      default: return '1;
    endcase
  endfunction

  task automatic queue_entry(input logic [31:0] v, input logic last, input logic clear);
    row_entry_t e;
    e.value = v;
    e.last = last;
    e.clear = clear;
    entries_to_send.push_back(e);
  endtask

  function automatic bit idling_on();
    return entries_to_send.size() >= 60 && ((entries_taken / 40) % 3 != 2);
  endfunction

  always @(posedge clk) begin
    in_took = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      in_took = 1'b1;
      entries_taken++;
      fold_entry(entry_value, row_end, new_matrix);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (entries_to_send.size() > 0) begin
        next_entry = entries_to_send.pop_front();
        entry_value <= next_entry.value;
        row_end <= next_entry.last;
        new_matrix <= next_entry.clear;
        in_valid <= 1'b1;
        if (idling_on() && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (idling_on() && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(1, 12) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result, out_value", out_value, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
        if (row_error !== want.err)
          report_mismatch("row_error", 32'(row_error), 32'(want.err));
        if (max_error !== want.peak)
          report_mismatch("max_error", 32'(max_error), 32'(want.peak));
        if (zero_row !== want.zero)
          report_mismatch("zero_row", 32'(zero_row), 32'(want.zero));
        if (last_out !== want.last)
          report_mismatch("last_out", 32'(last_out), 32'(want.last));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver stops for a long stretch so the block holds in its emit state and the input stalls.
  initial begin
    wait (entries_taken >= 120);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    int len;
    int kind;
    int clr_pos;
    int j;
    logic [31:0] v;

    queue_entry(ONE_FIX, 1'b1, 1'b1);
    queue_entry('0, 1'b0, 1'b0);
    queue_entry('0, 1'b0, 1'b0);
    queue_entry('0, 1'b1, 1'b0);
    queue_entry(srr_pkg::DATA_POS_MAX, 1'b0, 1'b0);
    queue_entry(~srr_pkg::DATA_POS_MAX, 1'b1, 1'b0);
    queue_entry(ONE_FIX / 2, 1'b0, 1'b0);
    queue_entry(-(ONE_FIX / 8), 1'b0, 1'b0);
    queue_entry(ONE_FIX, 1'b1, 1'b0);
    for (j = 0; j < ROW_MAX; j++)
      queue_entry((j % 3 == 0) ? 32'd0 : ONE_FIX / (j + 1), 1'b0, j == 5);

    while (entries_to_send.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      len = (kind < 70) ? $urandom_range(1, 5) :
            (kind < 90) ? $urandom_range(6, ROW_MAX - 1) : ROW_MAX;
      kind = $urandom_range(0, 19);
      clr_pos = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : -1;
      for (j = 0; j < len; j++) begin
        v = (kind == 0) ? 32'd0 : (kind == 1) ? $urandom() : pick_entry();
        queue_entry(v, (j == len - 1) && (len < ROW_MAX || $urandom_range(0, 1) == 1),
                    j == clr_pos);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (entries_to_send.size() > 0 || in_valid) @(posedge clk);
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d entries in %0d rows (%0d all-zero, %0d closed at capacity).",
             entries_taken, rows_closed, zero_rows, full_rows);
    $display("Checked %0d results; deepest projection took %0d passes.", results_seen,
             most_passes);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
